@@ src/rab_pkg.sv @@
// Package for range_and_bearing: widths, CORDIC angle table and gain constants.
package rab_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int GUARD_BITS = 16;
    localparam int ITERATIONS = 24;
    // datapath width: |vector| * gain stays below 2^42, one spare bit
    localparam int XW         = DIFF_W + GUARD_BITS + 3;
    localparam int MAG_W      = XW - 1;
    localparam int ANG_W      = 32;
    localparam int RANGE_W    = 25;
    localparam int BEAR_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int IN_TDATA_W  = 4 * COORD_W;
    localparam int OUT_TDATA_W = ((RANGE_W + BEAR_W + 7) / 8) * 8;

    localparam logic [ANG_W-1:0]  HALF_TURN       = 32'h8000_0000;
    localparam logic [BEAR_W-1:0] FULL_CIRCLE     = 17'd92160;
    // 1/K in Q32, split into 16-bit halves
    localparam logic [GAIN_W-1:0] INV_GAIN_HI     = 16'd39796;
    localparam logic [GAIN_W-1:0] INV_GAIN_LO     = 16'd60840;

    localparam logic [ANG_W-1:0] ATAN_TABLE [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

@@ src/range_and_bearing.sv @@
// Range and compass bearing between two points via a pipelined CORDIC vectoring unit.
// Pipeline: an accepted input beat passes through difference, prescale, 24 CORDIC stages,
// gain/scale multiply and round into the output register; every stage is a register.
// Throughput: one point pair per cycle unless the output stalls; all stages advance together.
// A stall at the output freezes the whole pipe; input ready is low whenever the output
// holds an untaken beat, however many stages behind it are empty.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; data registers are not reset.
module range_and_bearing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // from_x[23:0], from_y[47:24], to_x[71:48], to_y[95:72]
    input  logic [rab_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // range_out[24:0], bearing_out[41:25], zero pad [47:42]
    output logic [rab_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CW  = rab_pkg::COORD_W;
    localparam int DW  = rab_pkg::DIFF_W;
    localparam int XW  = rab_pkg::XW;
    localparam int MW  = rab_pkg::MAG_W;
    localparam int AW  = rab_pkg::ANG_W;
    localparam int GW  = rab_pkg::GAIN_W;
    localparam int NIT = rab_pkg::ITERATIONS;
    localparam int RW  = rab_pkg::RANGE_W;
    localparam int BW  = rab_pkg::BEAR_W;
    localparam int PW  = MW + GW;            // gain product width
    localparam int SW  = PW + 1;             // range sum width
    localparam int BPW = AW + BW;            // bearing product width
    localparam int SCALE = rab_pkg::GUARD_BITS + GW;

    // Global advance: the pipe moves unless the output holds an untaken beat.
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ---------------- stage 1: coordinate differences ----------------
    logic signed [CW-1:0] w_fx, w_fy, w_tx, w_ty;
    assign w_fx = i_s_tdata[CW-1:0];
    assign w_fy = i_s_tdata[2*CW-1:CW];
    assign w_tx = i_s_tdata[3*CW-1:2*CW];
    assign w_ty = i_s_tdata[4*CW-1:3*CW];

    logic                 r_v1;
    logic signed [DW-1:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= DW'(w_tx) - DW'(w_fx);
            r_dy <= DW'(w_ty) - DW'(w_fy);
        end
    end

    // ---------------- stage 2: scale, fold into northern half ----------------
    // north component drives the CORDIC x axis, east component the y axis
    logic signed [XW-1:0] r_x [0:NIT];
    logic signed [XW-1:0] r_y [0:NIT];
    logic        [AW-1:0] r_a [0:NIT];
    logic                 r_z [0:NIT];   // identical points
    logic                 r_v [0:NIT];

    logic signed [XW-1:0] w_xs, w_ys;
    assign w_xs = XW'(r_dy) <<< rab_pkg::GUARD_BITS;
    assign w_ys = XW'(r_dx) <<< rab_pkg::GUARD_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z[0] <= (r_dx == '0) && (r_dy == '0);
            if (r_dy[DW-1]) begin
                r_x[0] <= -w_xs;
                r_y[0] <= -w_ys;
                r_a[0] <= rab_pkg::HALF_TURN;
            end else begin
                r_x[0] <= w_xs;
                r_y[0] <= w_ys;
                r_a[0] <= '0;
            end
        end
    end

    // ---------------- CORDIC micro-rotations, one per stage ----------------
    for (genvar g = 0; g < NIT; g++) begin : g_iter
        localparam int SH = g % 32;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (w_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_z[g+1] <= r_z[g];
                if (!r_y[g][XW-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> SH);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> SH);
                    r_a[g+1] <= r_a[g] + rab_pkg::ATAN_TABLE[SH];
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> SH);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> SH);
                    r_a[g+1] <= r_a[g] - rab_pkg::ATAN_TABLE[SH];
                end
            end
        end
    end

    // ---------------- multiply: gain correction and degree scaling ----------------
    logic [MW-1:0] w_mag;
    assign w_mag = r_x[NIT][XW-1] ? '0 : r_x[NIT][MW-1:0];

    logic           r_vm, r_zm;
    logic [PW-1:0]  r_hi, r_lo;
    logic [BPW-1:0] r_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (w_en) begin
            r_vm <= r_v[NIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zm <= r_z[NIT];
            r_hi <= PW'(w_mag) * PW'(rab_pkg::INV_GAIN_HI);
            r_lo <= PW'(w_mag) * PW'(rab_pkg::INV_GAIN_LO);
            r_bp <= BPW'(r_a[NIT]) * BPW'(rab_pkg::FULL_CIRCLE);
        end
    end

    // ---------------- round and output register ----------------
    logic [SW-1:0]  w_rsum;
    logic [BPW:0]   w_bsum;
    logic [BW-1:0]  w_brg;
    assign w_rsum = SW'(r_hi) + SW'(r_lo >> GW) + (SW'(1) << (SCALE - 1));
    assign w_bsum = (BPW+1)'(r_bp) + ((BPW+1)'(1) << (AW - 1));
    assign w_brg  = w_bsum[AW+BW-1:AW];

    logic          r_vo;
    logic [RW-1:0] r_rng;
    logic [BW-1:0] r_brg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zm) begin
                r_rng <= '0;
                r_brg <= '0;
            end else begin
                r_rng <= w_rsum[SCALE+RW-1:SCALE];
                r_brg <= (w_brg >= rab_pkg::FULL_CIRCLE) ? '0 : w_brg;
            end
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {(rab_pkg::OUT_TDATA_W - RW - BW)'(0), r_brg, r_rng};

    // ---------------- assertions ----------------
    // bearing never reaches a full turn
    a_brg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_brg < rab_pkg::FULL_CIRCLE))
        else $error("bearing out of range");

    // fold into the northern half leaves a non-negative x operand
    a_fold_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> !r_x[0][XW-1])
        else $error("prescaled x negative");

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // identical points give zero range
    a_zero_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vm && r_zm) |=> (r_rng == '0))
        else $error("identical points gave non-zero range");

endmodule
